### src/rptu_pkg.sv
// Package for the radix page table unit: field widths, codes, entry bits and helpers.
`timescale 1ns / 1ps

package rptu_pkg;

  // Field widths
  localparam int VA_W    = 48;
  localparam int PA_W    = 52;
  localparam int FRAME_W = 40;  // physical address bits 51..12
  localparam int ENTRY_W = 64;
  localparam int SLOT_W  = 9;
  localparam int LVL_W   = 2;

  // Request kinds
  localparam logic [1:0] KIND_MAP       = 2'd0;
  localparam logic [1:0] KIND_UNMAP     = 2'd1;
  localparam logic [1:0] KIND_TRANSLATE = 2'd2;
  localparam logic [1:0] KIND_FLAGS     = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_MISALIGNED = 2'd1;
  localparam logic [1:0] ST_EXHAUSTED  = 2'd2;
  localparam logic [1:0] ST_NOT_MAPPED = 2'd3;

  // Walk levels: three directory levels then the leaf
  localparam logic [1:0] LVL_ROOT     = 2'd0;
  localparam logic [1:0] LVL_LAST_DIR = 2'd2;
  localparam logic [1:0] LVL_LEAF     = 2'd3;

  // Entry bit positions (x86 layout)
  localparam int E_PRESENT = 0;
  localparam int E_WRITE   = 1;
  localparam int E_USER    = 2;
  localparam int E_GLOBAL  = 8;
  localparam int E_NX      = 63;

  // Result of the shared link unit
  typedef struct packed {
    logic               ok;         // entry points at an allocated table
    logic [FRAME_W-1:0] off;        // table offset of the entry from the pool base
    logic [FRAME_W-1:0] new_frame;  // frame of the next table to allocate
  } link_t;

  // 9-bit table index of a virtual address at a given level
  function automatic logic [SLOT_W-1:0] slot_of(input logic [VA_W-1:0] va,
                                                input logic [LVL_W-1:0] lvl);
    logic [SLOT_W-1:0] s;
    begin
      case (lvl)
        LVL_ROOT:     s = va[47:39];
        2'd1:         s = va[38:30];
        LVL_LAST_DIR: s = va[29:21];
        default:      s = va[20:12];
      endcase
      return s;
    end
  endfunction

endpackage

### src/rptu_if.sv
// Request and response channel interfaces of the radix page table unit.
`timescale 1ns / 1ps

interface rptu_req_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  kind;
  logic [rptu_pkg::VA_W-1:0]   virt_addr;
  logic [rptu_pkg::PA_W-1:0]   phys_addr;
  logic [3:0]                  map_flags;

  modport source (output valid, kind, virt_addr, phys_addr, map_flags, input ready);
  modport sink   (input valid, kind, virt_addr, phys_addr, map_flags, output ready);
endinterface

interface rptu_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [rptu_pkg::PA_W-1:0]   phys_result;
  logic [4:0]                  flags_result;
  logic                        invalidate_request;

  modport source (output valid, status, phys_result, flags_result, invalidate_request,
                  input ready);
  modport sink   (input valid, status, phys_result, flags_result, invalidate_request,
                  output ready);
endinterface

### src/rptu_link_unit.sv
// Shared link unit: decodes a directory entry into a pool table and encodes new links.
`timescale 1ns / 1ps

module rptu_link_unit #(
  parameter int POOL_TABLES = 16,
  parameter int NF_W        = 5
) (
  input  logic [rptu_pkg::FRAME_W-1:0] entry_frame,
  input  logic [rptu_pkg::FRAME_W-1:0] base_frame,
  input  logic [NF_W-1:0]              next_free,
  output rptu_pkg::link_t              link
);

  logic [rptu_pkg::FRAME_W-1:0] nf_ext;

  assign nf_ext = rptu_pkg::FRAME_W'(next_free);

  // Offset wraps within the 40-bit frame space, as the base does
  assign link.off       = entry_frame - base_frame;
  assign link.ok        = (link.off < nf_ext);
  assign link.new_frame = base_frame + nf_ext;

endmodule

### src/rptu_cfg_regs.sv
// APB-style configuration registers: table pool base and active-space flag.
`timescale 1ns / 1ps

module rptu_cfg_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [3:0]                paddr,
  input  logic [63:0]               pwdata,
  output logic [63:0]               prdata,
  output logic                      pready,
  output logic [rptu_pkg::PA_W-1:0] pool_base,
  output logic                      space_active
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  // Register 0 at byte 0, register 1 at byte 8
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base    <= '0;
      space_active <= 1'b1;
    end else if (wr) begin
      if (paddr[3]) begin
        space_active <= pwdata[0];
      end else begin
        pool_base <= pwdata[rptu_pkg::PA_W-1:0];
      end
    end
  end

  // Read back
  always_comb begin
    if (paddr[3]) begin
      prdata = {63'd0, space_active};
    end else begin
      prdata = {12'd0, pool_base};
    end
  end

endmodule

### src/radix_page_table_unit.sv
// Top level: four-level page table walker with on-chip table pool and walk sequencer.
//
//   channel  dir   handshake          payload
//   req      in    valid/ready        kind, virt_addr, phys_addr, map_flags
//   rsp      out   valid/ready        status, phys_result, flags_result, invalidate_request
//   apb      in    psel/penable       paddr, pwdata -> prdata (pready always high)
//
// Each directory level is a table read (S_READ), then a check/link (S_CHECK). A misaligned
// beat goes straight to S_DONE; a walk may also stop there at a missing, stale or exhausted
// level. Map and unmap write the leaf in S_LEAF; translate and read flags read it back. From
// S_DONE the result enters the output register, and req.ready returns in that same cycle.
// The pace is set by the single table memory with its registered read port and the one
// shared link unit. After reset a clearing pass zeroes the pool; req.ready stays low.
// A finished result waits in the output register; the next beat may be taken meanwhile,
// and the walker holds its result until the output register is free.
`timescale 1ns / 1ps

module radix_page_table_unit #(
  parameter int POOL_TABLES = 16
) (
  input  logic              clk,
  input  logic              rst,
  rptu_req_if.sink          req,
  rptu_rsp_if.source        rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);

  localparam int TW    = $clog2(POOL_TABLES);
  localparam int AW    = TW + rptu_pkg::SLOT_W;
  localparam int DEPTH = POOL_TABLES * 512;
  localparam int NF_W  = $clog2(POOL_TABLES + 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_LEAF  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  // Control state
  logic [2:0]      state, state_next;
  logic [AW-1:0]   clr_addr, clr_addr_next;
  logic [NF_W-1:0] next_free, next_free_next;
  logic            out_valid;

  // Item and walk registers
  logic [1:0]                  kind_q, kind_q_next;
  logic [rptu_pkg::VA_W-1:0]   virt_q, virt_q_next;
  logic [rptu_pkg::PA_W-1:0]   phys_q, phys_q_next;
  logic [3:0]                  flags_q, flags_q_next;
  logic [rptu_pkg::LVL_W-1:0]  level, level_next;
  logic [TW-1:0]               tbl, tbl_next;

  // Walk result, then output register
  logic [1:0]                  res_status, res_status_next;
  logic [rptu_pkg::PA_W-1:0]   res_phys, res_phys_next;
  logic [4:0]                  res_flags, res_flags_next;
  logic                        res_inv, res_inv_next;
  logic [1:0]                  out_status;
  logic [rptu_pkg::PA_W-1:0]   out_phys;
  logic [4:0]                  out_flags;
  logic                        out_inv;
  logic                        load_out;

  // Table memory
  logic [rptu_pkg::ENTRY_W-1:0] table_mem [DEPTH];
  logic [rptu_pkg::ENTRY_W-1:0] rd_data;
  logic [rptu_pkg::ENTRY_W-1:0] mem_wdata;
  logic [AW-1:0]                mem_waddr;
  logic [AW-1:0]                cur_addr;
  logic                         mem_we;
  logic [rptu_pkg::SLOT_W-1:0]  slot;

  logic [rptu_pkg::PA_W-1:0]    pool_base;
  logic                         space_active;
  rptu_pkg::link_t              link;
  logic                         misaligned;

  rptu_cfg_regs u_cfg (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .pool_base    (pool_base),
    .space_active (space_active)
  );

  rptu_link_unit #(
    .POOL_TABLES (POOL_TABLES),
    .NF_W        (NF_W)
  ) u_link (
    .entry_frame (rd_data[51:12]),
    .base_frame  (pool_base[51:12]),
    .next_free   (next_free),
    .link        (link)
  );

  assign slot     = rptu_pkg::slot_of(virt_q, level);
  assign cur_addr = {tbl, slot};

  // Channel outputs
  assign req.ready              = (state == S_IDLE);
  assign rsp.valid              = out_valid;
  assign rsp.status             = out_status;
  assign rsp.phys_result        = out_phys;
  assign rsp.flags_result       = out_flags;
  assign rsp.invalidate_request = out_inv;

  assign misaligned = ((req.kind == rptu_pkg::KIND_MAP) &&
                       ((req.virt_addr[11:0] != 12'd0) || (req.phys_addr[11:0] != 12'd0))) ||
                      ((req.kind == rptu_pkg::KIND_UNMAP) && (req.virt_addr[11:0] != 12'd0));

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= table_mem[cur_addr];
  end

  // Walk sequencer
  always_comb begin
    state_next      = state;
    clr_addr_next   = clr_addr;
    next_free_next  = next_free;
    kind_q_next     = kind_q;
    virt_q_next     = virt_q;
    phys_q_next     = phys_q;
    flags_q_next    = flags_q;
    level_next      = level;
    tbl_next        = tbl;
    res_status_next = res_status;
    res_phys_next   = res_phys;
    res_flags_next  = res_flags;
    res_inv_next    = res_inv;
    mem_we          = 1'b0;
    mem_waddr       = cur_addr;
    mem_wdata       = '0;
    load_out        = 1'b0;

    case (state)
      S_CLEAR: begin
        mem_we        = 1'b1;
        mem_waddr     = clr_addr;
        clr_addr_next = clr_addr + AW'(1);
        if (clr_addr == AW'(DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (req.valid) begin
          kind_q_next     = req.kind;
          virt_q_next     = req.virt_addr;
          phys_q_next     = req.phys_addr;
          flags_q_next    = req.map_flags;
          level_next      = rptu_pkg::LVL_ROOT;
          tbl_next        = '0;
          res_status_next = rptu_pkg::ST_OK;
          res_phys_next   = '0;
          res_flags_next  = '0;
          res_inv_next    = 1'b0;
          if (misaligned) begin
            res_status_next = rptu_pkg::ST_MISALIGNED;
            state_next      = S_DONE;
          end else begin
            state_next = S_READ;
          end
        end
      end

      S_READ: begin
        state_next = S_CHECK;
      end

      S_CHECK: begin
        if (level == rptu_pkg::LVL_LEAF) begin
          // Leaf lookup for translate and read flags
          state_next = S_DONE;
          if (!rd_data[rptu_pkg::E_PRESENT]) begin
            res_status_next = rptu_pkg::ST_NOT_MAPPED;
          end else if (kind_q == rptu_pkg::KIND_TRANSLATE) begin
            res_phys_next = {rd_data[51:12], virt_q[11:0]};
          end else begin
            res_flags_next = {rd_data[rptu_pkg::E_NX], rd_data[rptu_pkg::E_GLOBAL],
                              rd_data[rptu_pkg::E_USER], rd_data[rptu_pkg::E_WRITE], 1'b1};
          end
        end else if (rd_data[rptu_pkg::E_PRESENT]) begin
          // Follow an existing link
          if (link.ok) begin
            tbl_next   = link.off[TW-1:0];
            level_next = level + 2'd1;
            state_next = (level == rptu_pkg::LVL_LAST_DIR) ? S_LEAF : S_READ;
          end else begin
            res_status_next = rptu_pkg::ST_NOT_MAPPED;
            state_next      = S_DONE;
          end
        end else if (kind_q != rptu_pkg::KIND_MAP) begin
          res_status_next = rptu_pkg::ST_NOT_MAPPED;
          state_next      = S_DONE;
        end else if (next_free >= NF_W'(POOL_TABLES)) begin
          res_status_next = rptu_pkg::ST_EXHAUSTED;
          state_next      = S_DONE;
        end else begin
          // Allocate a table (already zero) and link it
          mem_we         = 1'b1;
          mem_wdata      = {12'd0, link.new_frame, 9'd0, flags_q[1], 1'b1, 1'b1};
          tbl_next       = next_free[TW-1:0];
          next_free_next = next_free + NF_W'(1);
          level_next     = level + 2'd1;
          state_next     = (level == rptu_pkg::LVL_LAST_DIR) ? S_LEAF : S_READ;
        end
      end

      S_LEAF: begin
        if (kind_q == rptu_pkg::KIND_MAP) begin
          mem_we       = 1'b1;
          mem_wdata    = {flags_q[3], 11'd0, phys_q[51:12], 3'd0, flags_q[2], 5'd0,
                          flags_q[1], flags_q[0], 1'b1};
          res_inv_next = space_active;
          state_next   = S_DONE;
        end else if (kind_q == rptu_pkg::KIND_UNMAP) begin
          mem_we       = 1'b1;
          mem_wdata    = '0;
          res_inv_next = space_active;
          state_next   = S_DONE;
        end else begin
          state_next = S_READ;
        end
      end

      S_DONE: begin
        if (!out_valid || rsp.ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      next_free <= NF_W'(1);
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_addr  <= clr_addr_next;
      next_free <= next_free_next;
      out_valid <= load_out || (out_valid && !rsp.ready);
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    kind_q     <= kind_q_next;
    virt_q     <= virt_q_next;
    phys_q     <= phys_q_next;
    flags_q    <= flags_q_next;
    level      <= level_next;
    tbl        <= tbl_next;
    res_status <= res_status_next;
    res_phys   <= res_phys_next;
    res_flags  <= res_flags_next;
    res_inv    <= res_inv_next;
    if (load_out) begin
      out_status <= res_status;
      out_phys   <= res_phys;
      out_flags  <= res_flags;
      out_inv    <= res_inv;
    end
  end

  // Checks
  a_accept_starts_walk: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state != S_IDLE))
    else $error("walker stayed idle after an accepted beat");

  a_pool_bound: assert property (@(posedge clk) disable iff (rst)
    (next_free <= NF_W'(POOL_TABLES)) && (next_free != '0))
    else $error("table allocation counter out of range");

  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.status != rptu_pkg::ST_OK)) |->
      ((rsp.phys_result == '0) && (rsp.flags_result == '0) && !rsp.invalidate_request))
    else $error("failed request returned non-zero result fields");

  a_write_present: assert property (@(posedge clk) disable iff (rst)
    (mem_we && (state != S_CLEAR)) |->
      (mem_wdata[rptu_pkg::E_PRESENT] || (kind_q == rptu_pkg::KIND_UNMAP)))
    else $error("walk wrote a non-present entry outside unmap");

endmodule

### sim/radix_page_table_unit_test.sv
// Self-checking testbench for the radix page table unit: table mirror, stimulus and checks.
`timescale 1ns / 1ps

module radix_page_table_unit_test;

  localparam int POOL_TABLES   = 16;
  localparam int TABLE_ENTRIES = 512;
  localparam int STALL_LIMIT   = 40000;  // covers the clearing pass after reset
  localparam int DRAIN_CYCLES  = 20;

  // Register byte addresses (64-bit registers, 8-byte stride)
  localparam logic [3:0] REG_POOL_BASE    = 4'h0;
  localparam logic [3:0] REG_SPACE_ACTIVE = 4'h8;

  // map_flags bits
  localparam int MF_WRITE  = 0;
  localparam int MF_USER   = 1;
  localparam int MF_GLOBAL = 2;
  localparam int MF_NX     = 3;

  // flags_result bits
  localparam int FR_PRESENT = 0;
  localparam int FR_WRITE   = 1;
  localparam int FR_USER    = 2;
  localparam int FR_GLOBAL  = 3;
  localparam int FR_NX      = 4;

  typedef struct packed {
    logic [1:0]                kind;
    logic [rptu_pkg::VA_W-1:0] virt;
    logic [rptu_pkg::PA_W-1:0] phys;
    logic [3:0]                flags;
  } page_req_t;

  typedef struct packed {
    logic [1:0]                status;
    logic [rptu_pkg::PA_W-1:0] phys;
    logic [4:0]                flags;
    logic                      inval;
  } page_rsp_t;

  // Mirror of the page table pool; predicts one result per request
  class page_table_mirror;
    logic [rptu_pkg::ENTRY_W-1:0] table_mem [POOL_TABLES*TABLE_ENTRIES];
    int unsigned                  tables_used;
    logic [rptu_pkg::PA_W-1:0]    pool_base;
    bit                           space_active;
    page_rsp_t                    awaited_results [$];
    int                           errors;

    function new();
      foreach (table_mem[i]) table_mem[i] = '0;
      tables_used  = 1;
      pool_base    = '0;
      space_active = 1'b1;
      errors       = 0;
    endfunction

    function void write_reg(input logic [3:0] addr, input logic [63:0] value);
      if (addr == REG_POOL_BASE) pool_base = value[rptu_pkg::PA_W-1:0];
      else if (addr == REG_SPACE_ACTIVE) space_active = value[0];
    endfunction

    // Walk the three directory levels; may link new tables on a map
    function logic [1:0] walk_to_leaf(input logic [rptu_pkg::VA_W-1:0] va, input bit create,
                                      input bit user, output int unsigned leaf_tbl);
      int unsigned                  tbl;
      int unsigned                  i;
      logic [rptu_pkg::SLOT_W-1:0]  slot;
      logic [rptu_pkg::ENTRY_W-1:0] ent;
      logic [rptu_pkg::FRAME_W-1:0] link_idx;
      tbl = 0;
      leaf_tbl = 0;
      for (int lvl = 0; lvl < 3; lvl++) begin
        slot = 9'(va >> (39 - 9*lvl));
        ent  = table_mem[tbl*TABLE_ENTRIES + slot];
        if (ent[rptu_pkg::E_PRESENT]) begin
          // link must land on an allocated table at the current base
          link_idx = ent[51:12] - pool_base[51:12];
          if (link_idx >= tables_used || link_idx >= POOL_TABLES)
            return rptu_pkg::ST_NOT_MAPPED;
          tbl = link_idx[31:0];
        end else begin
          if (!create) return rptu_pkg::ST_NOT_MAPPED;
          if (tables_used >= POOL_TABLES) return rptu_pkg::ST_EXHAUSTED;
          for (i = 0; i < TABLE_ENTRIES; i++) table_mem[tables_used*TABLE_ENTRIES + i] = '0;
          ent = '0;
          ent[51:12]               = pool_base[51:12] + tables_used;
          ent[rptu_pkg::E_PRESENT] = 1'b1;
          ent[rptu_pkg::E_WRITE]   = 1'b1;
          ent[rptu_pkg::E_USER]    = user;
          table_mem[tbl*TABLE_ENTRIES + slot] = ent;
          tbl = tables_used;
          tables_used++;
        end
      end
      leaf_tbl = tbl;
      return rptu_pkg::ST_OK;
    endfunction

    function void note_request(input page_req_t r);
      page_rsp_t                    want;
      int unsigned                  leaf;
      logic [rptu_pkg::SLOT_W-1:0]  slot;
      logic [rptu_pkg::ENTRY_W-1:0] ent;
      want = '0;
      slot = r.virt[20:12];
      case (r.kind)
        rptu_pkg::KIND_MAP: begin
          if (r.virt[11:0] != 0 || r.phys[11:0] != 0) begin
            want.status = rptu_pkg::ST_MISALIGNED;
          end else begin
            want.status = walk_to_leaf(r.virt, 1'b1, r.flags[MF_USER], leaf);
            if (want.status == rptu_pkg::ST_OK) begin
              ent = '0;
              ent[51:12]               = r.phys[51:12];
              ent[rptu_pkg::E_PRESENT] = 1'b1;
              ent[rptu_pkg::E_WRITE]   = r.flags[MF_WRITE];
              ent[rptu_pkg::E_USER]    = r.flags[MF_USER];
              ent[rptu_pkg::E_GLOBAL]  = r.flags[MF_GLOBAL];
              ent[rptu_pkg::E_NX]      = r.flags[MF_NX];
              table_mem[leaf*TABLE_ENTRIES + slot] = ent;
              want.inval = space_active;
            end
          end
        end
        rptu_pkg::KIND_UNMAP: begin
          if (r.virt[11:0] != 0) begin
            want.status = rptu_pkg::ST_MISALIGNED;
          end else begin
            want.status = walk_to_leaf(r.virt, 1'b0, 1'b0, leaf);
            if (want.status == rptu_pkg::ST_OK) begin
              // cleared and invalidated even when the leaf was empty
              table_mem[leaf*TABLE_ENTRIES + slot] = '0;
              want.inval = space_active;
            end
          end
        end
        default: begin
          want.status = walk_to_leaf(r.virt, 1'b0, 1'b0, leaf);
          if (want.status == rptu_pkg::ST_OK) begin
            ent = table_mem[leaf*TABLE_ENTRIES + slot];
            if (!ent[rptu_pkg::E_PRESENT]) begin
              want.status = rptu_pkg::ST_NOT_MAPPED;
            end else if (r.kind == rptu_pkg::KIND_TRANSLATE) begin
              want.phys = {ent[51:12], r.virt[11:0]};
            end else begin
              want.flags[FR_PRESENT] = 1'b1;
              want.flags[FR_WRITE]   = ent[rptu_pkg::E_WRITE];
              want.flags[FR_USER]    = ent[rptu_pkg::E_USER];
              want.flags[FR_GLOBAL]  = ent[rptu_pkg::E_GLOBAL];
              want.flags[FR_NX]      = ent[rptu_pkg::E_NX];
            end
          end
        end
      endcase
      awaited_results.push_back(want);
    endfunction

    function void check_response(input page_rsp_t got);
      page_rsp_t want;
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result beat: status %0d phys %h flags %h inval %0d",
                 $time, got.status, got.phys, got.flags, got.inval);
        errors++;
        return;
      end
      want = awaited_results.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status mismatch: expected %0d, actual %0d",
                 $time, want.status, got.status);
        errors++;
      end
      if (got.phys !== want.phys) begin
        $display("%0t: phys_result mismatch: expected %h, actual %h",
                 $time, want.phys, got.phys);
        errors++;
      end
      if (got.flags !== want.flags) begin
        $display("%0t: flags_result mismatch: expected %h, actual %h",
                 $time, want.flags, got.flags);
        errors++;
      end
      if (got.inval !== want.inval) begin
        $display("%0t: invalidate_request mismatch: expected %0d, actual %0d",
                 $time, want.inval, got.inval);
        errors++;
      end
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  rptu_req_if req ();
  rptu_rsp_if rsp ();

  page_table_mirror mirror = new();
  int sender_idle_pct;
  int receiver_idle_pct;
  int quiet_cycles;

  radix_page_table_unit #(
    .POOL_TABLES(POOL_TABLES)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // Result side: random back-pressure and checking
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready)
        mirror.check_response(page_rsp_t'{status: rsp.status, phys: rsp.phys_result,
                                          flags: rsp.flags_result,
                                          inval: rsp.invalidate_request});
      rsp.ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // Watchdog: too long without any beat or register access
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready) || psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  function automatic page_req_t page_req(input logic [1:0] kind,
                                         input logic [rptu_pkg::VA_W-1:0] va,
                                         input logic [rptu_pkg::PA_W-1:0] pa,
                                         input logic [3:0] fl);
    return page_req_t'{kind: kind, virt: va, phys: pa, flags: fl};
  endfunction

  // Directory index: a few hot values so walks share tables
  function automatic logic [rptu_pkg::SLOT_W-1:0] pick_dir_index();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 9'h000;
    else if (r < 85) return 9'h1FF;
    else return 9'h0A5;
  endfunction

  function automatic logic [rptu_pkg::SLOT_W-1:0] pick_leaf_index();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 25) return 9'h000;
    else if (r < 40) return 9'h1FF;
    else if (r < 55) return 9'h001;
    else if (r < 70) return 9'h155;
    else return 9'($urandom_range(511));
  endfunction

  function automatic page_req_t random_request();
    page_req_t   r;
    logic [63:0] w;
    int unsigned pick;
    w = {$urandom(), $urandom()};
    r.phys  = w[rptu_pkg::PA_W-1:0];
    r.flags = 4'($urandom_range(15));
    if ($urandom_range(99) < 10) begin
      // noise: anything at all
      r.kind = 2'($urandom_range(3));
      w = {$urandom(), $urandom()};
      r.virt = w[rptu_pkg::VA_W-1:0];
      return r;
    end
    pick = $urandom_range(99);
    if (pick < 35) r.kind = rptu_pkg::KIND_MAP;
    else if (pick < 50) r.kind = rptu_pkg::KIND_UNMAP;
    else if (pick < 75) r.kind = rptu_pkg::KIND_TRANSLATE;
    else r.kind = rptu_pkg::KIND_FLAGS;
    r.virt = {pick_dir_index(), pick_dir_index(), pick_dir_index(), pick_leaf_index(),
              12'h000};
    if (r.kind == rptu_pkg::KIND_TRANSLATE || r.kind == rptu_pkg::KIND_FLAGS ||
        $urandom_range(99) < 10)
      r.virt[11:0] = 12'($urandom_range(4095));
    if ($urandom_range(99) < 90) r.phys[11:0] = '0;
    return r;
  endfunction

  task automatic send_request(input page_req_t r);
    if ($urandom_range(99) < sender_idle_pct) begin
      req.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    req.valid     <= 1'b1;
    req.kind      <= r.kind;
    req.virt_addr <= r.virt;
    req.phys_addr <= r.phys;
    req.map_flags <= r.flags;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    mirror.note_request(r);
  endtask

  task automatic run_random(input int count);
    for (int n = 0; n < count; n++) send_request(random_request());
  endtask

  // Stop sending and wait for every outstanding result
  task automatic finish_phase();
    req.valid <= 1'b0;
    while (mirror.pending() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [3:0] addr, input logic [63:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    mirror.write_reg(addr, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    rst           <= 1'b1;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    req.valid     <= 1'b0;
    req.kind      <= rptu_pkg::KIND_MAP;
    req.virt_addr <= '0;
    req.phys_addr <= '0;
    req.map_flags <= '0;
    sender_idle_pct   = 18;
    receiver_idle_pct = 77;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Base zero, junk in the ignored low and high bits
    write_register(REG_POOL_BASE, 64'hFFF0_0000_0000_0ABC);
    write_register(REG_SPACE_ACTIVE, 64'h1);

    // Directed: empty table, misalignment, extremes, overwrite, empty leaf
    send_request(page_req(rptu_pkg::KIND_TRANSLATE, 48'h0, 52'h0, 4'h0));
    send_request(page_req(rptu_pkg::KIND_FLAGS, 48'hFFFF_FFFF_FFFF, 52'h0, 4'h0));
    send_request(page_req(rptu_pkg::KIND_UNMAP, 48'h0, 52'h0, 4'h0));
    send_request(page_req(rptu_pkg::KIND_MAP, 48'h123, 52'h0, 4'hF));
    send_request(page_req(rptu_pkg::KIND_MAP, 48'h0, 52'h800, 4'hF));
    send_request(page_req(rptu_pkg::KIND_UNMAP, 48'h800, 52'h0, 4'h0));
    send_request(page_req(rptu_pkg::KIND_MAP, 48'h0, 52'hF_FFFF_FFFF_F000, 4'hF));
    send_request(page_req(rptu_pkg::KIND_TRANSLATE, 48'hFFF, 52'h0, 4'h0));
    send_request(page_req(rptu_pkg::KIND_FLAGS, 48'h0, 52'h0, 4'h0));
    send_request(page_req(rptu_pkg::KIND_MAP, 48'hFFFF_FFFF_F000, 52'h0, 4'h0));
    send_request(page_req(rptu_pkg::KIND_TRANSLATE, 48'hFFFF_FFFF_FFFF, 52'h0, 4'h0));
    send_request(page_req(rptu_pkg::KIND_FLAGS, 48'hFFFF_FFFF_F123, 52'h0, 4'h0));
    send_request(page_req(rptu_pkg::KIND_MAP, 48'h0, 52'h0_1234_5678_9000, 4'h5));
    send_request(page_req(rptu_pkg::KIND_FLAGS, 48'h7FF, 52'h0, 4'h0));
    send_request(page_req(rptu_pkg::KIND_UNMAP, 48'h1000, 52'h0, 4'h0));
    send_request(page_req(rptu_pkg::KIND_TRANSLATE, 48'h1ABC, 52'h0, 4'h0));
    send_request(page_req(rptu_pkg::KIND_MAP, 48'h0000_4000_0000, 52'hA_5A5A_5A5A_5000,
                          4'hA));
    send_request(page_req(rptu_pkg::KIND_TRANSLATE, 48'h0000_4000_0ABC, 52'h0, 4'h0));
    send_request(page_req(rptu_pkg::KIND_UNMAP, 48'h0, 52'h0, 4'h0));
    send_request(page_req(rptu_pkg::KIND_TRANSLATE, 48'h0, 52'h0, 4'h0));
    send_request(page_req(rptu_pkg::KIND_FLAGS, 48'h0, 52'h0, 4'h0));
    send_request(page_req(rptu_pkg::KIND_UNMAP, 48'h0080_0000_0000, 52'h0, 4'h0));
    run_random(430);
    finish_phase();

    // Inactive space: no invalidations
    sender_idle_pct   = 77;
    receiver_idle_pct = 18;
    write_register(REG_SPACE_ACTIVE, 64'h0);
    run_random(350);
    finish_phase();

    // Top pool base: existing links shift by one table or go stale, new ones wrap at 52 bits
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    write_register(REG_POOL_BASE, 64'hFFFF_FFFF_FFFF_FFFF);
    write_register(REG_SPACE_ACTIVE, 64'h1);
    run_random(200);
    finish_phase();

    // Back to base zero: the first links are valid again
    write_register(REG_POOL_BASE, 64'h0);
    run_random(150);
    finish_phase();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mirror.errors == 0 && mirror.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### filelist.f
src/rptu_pkg.sv
src/rptu_if.sv
src/rptu_link_unit.sv
src/rptu_cfg_regs.sv
src/radix_page_table_unit.sv
sim/radix_page_table_unit_test.sv
